// ----- rtl/drrip_pkg.sv -----
`default_nettype none
package drrip_pkg;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int SIG_BITS    = 6;
    localparam int SEL_BITS    = 10;
    localparam int SET_W       = $clog2(SETS);
    localparam int WAY_W       = $clog2(WAYS);
    localparam int SIG_ENTRIES = 1 << SIG_BITS;
    localparam int CFG_W       = 16;
    localparam int LEAD_W      = 11;

    localparam logic CFG_DECAY_PERIOD = 1'b0;
    localparam logic CFG_LEADER_COUNT = 1'b1;

    typedef struct packed {
        logic [WAYS-1:0][SIG_BITS-1:0] sig;
        logic [WAYS-1:0][1:0]          dead;
        logic [WAYS-1:0][1:0]          rrpv;
    } row_t;

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_SWEEP     = 8'b0000_0100,
        S_SWEEP_END = 8'b0000_1000,
        S_READ      = 8'b0001_0000,
        S_EVAL      = 8'b0010_0000,
        S_FINISH    = 8'b0100_0000,
        S_PUSH      = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic sweep_rd;
        logic row_rd;
        logic tbl_rd;
        logic finish;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic decay_now;
        logic ptr_last;
    } status_t;

endpackage
`default_nettype wire

// ----- rtl/drrip_ctrl.sv -----
`default_nettype none
module drrip_ctrl
    import drrip_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.ptr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.decay_now ? S_SWEEP : S_READ;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (status.ptr_last)
                    state_next = S_SWEEP_END;
            end
            S_SWEEP_END: state_next = S_READ;
            S_READ:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        if (cmd.push)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/drrip_dp.sv -----
`default_nettype none
module drrip_dp
    import drrip_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               operation,
    input  wire logic [10:0]        set_index,
    input  wire logic [3:0]         way_index,
    input  wire logic [15:0]        valid_mask,
    input  wire logic [5:0]         pc_low,
    input  wire logic [5:0]         line_addr_low,
    input  wire logic               was_hit,
    output logic [3:0]              victim_way,
    output logic [1:0]              written_rrpv
);

    localparam logic [SEL_BITS-1:0] SEL_MID = SEL_BITS'(1 << (SEL_BITS - 1));
    localparam logic [SEL_BITS-1:0] SEL_MAX = '1;

    logic [15:0]            period_reg;
    logic [LEAD_W-1:0]      lead_reg;
    logic [15:0]            dc_reg;
    logic [15:0]            lfsr_reg, lfsr_next;
    logic [SEL_BITS-1:0]    psel_reg, psel_next;
    logic [SIG_ENTRIES-1:0] tvalid_reg;

    logic                   op_reg, hit_reg;
    logic [SET_W-1:0]       set_reg;
    logic [WAY_W-1:0]       way_reg;
    logic [WAYS-1:0]        mask_reg;
    logic [SIG_BITS-1:0]    sig_reg;

    logic [SET_W-1:0]       ptr_reg, wptr_reg;
    logic                   swv_reg;

    row_t                   mem [SETS];
    row_t                   row_reg;
    logic [1:0]             tbl_mem [SIG_ENTRIES];
    logic [1:0]             tbl_q_reg;
    logic                   tbl_v_reg;
    logic [SIG_BITS-1:0]    ts_reg, ts_next;

    logic [WAY_W-1:0]       res_way_reg, res_way_next;
    logic [1:0]             res_rrpv_reg, res_rrpv_next;
    logic [3:0]             out_way_reg;
    logic [1:0]             out_rrpv_reg;

    logic [15:0]            dc_inc;
    logic                   mem_we, mem_re, fin_we, tbl_we;
    logic [SET_W-1:0]       mem_wa, mem_ra;
    row_t                   mem_wd, clr_row, swp_row, fin_row;

    logic                   any_inv;
    logic [WAY_W-1:0]       first_inv, first3;
    logic [1:0]             top;
    logic [WAYS-1:0][1:0]   aged;
    logic [1:0]             dead_old, dead_new, tcur, t_new, ins, lfsr_pick;
    logic                   srrip, brrip, lfsr_use;
    logic [LEAD_W+1:0]      lead_sum;

    assign dc_inc           = dc_reg + 16'd1;
    assign status.decay_now = operation && (dc_inc >= period_reg);
    assign status.ptr_last  = (ptr_reg == SET_W'(SETS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 16'd4096;
            lead_reg   <= LEAD_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DECAY_PERIOD: period_reg <= cfg_data;
                CFG_LEADER_COUNT: lead_reg   <= cfg_data[LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            set_reg  <= set_index[SET_W-1:0];
            way_reg  <= way_index[WAY_W-1:0];
            mask_reg <= valid_mask[WAYS-1:0];
            sig_reg  <= SIG_BITS'(pc_low ^ line_addr_low);
            hit_reg  <= was_hit;
        end
    end

    // Row memory: clearing pass, decay sweep and per-item read-modify-write
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            clr_row.rrpv[w] = 2'd2;
            clr_row.dead[w] = 2'd0;
            clr_row.sig[w]  = '0;
            swp_row.rrpv[w] = row_reg.rrpv[w];
            swp_row.sig[w]  = row_reg.sig[w];
            swp_row.dead[w] = (row_reg.dead[w] != 2'd0) ? row_reg.dead[w] - 2'd1 : 2'd0;
        end
    end

    assign mem_re = cmd.sweep_rd | cmd.row_rd;
    assign mem_ra = cmd.sweep_rd ? ptr_reg : set_reg;
    assign mem_we = cmd.clr_wr | swv_reg | (cmd.finish & fin_we);

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            mem_wa = ptr_reg;
            mem_wd = clr_row;
        end
        else if (swv_reg)
        begin
            mem_wa = wptr_reg;
            mem_wd = swp_row;
        end
        else
        begin
            mem_wa = set_reg;
            mem_wd = fin_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            row_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            swv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr || cmd.sweep_rd)
                ptr_reg <= ptr_reg + SET_W'(1);
            swv_reg <= cmd.sweep_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        wptr_reg <= ptr_reg;
    end

    // Outcome table
    assign ts_next = hit_reg ? row_reg.sig[way_reg] : sig_reg;
    assign tbl_we  = cmd.finish & op_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[ts_reg] <= t_new;
        if (cmd.tbl_rd)
        begin
            tbl_q_reg <= tbl_mem[ts_next];
            tbl_v_reg <= tvalid_reg[ts_next];
            ts_reg    <= ts_next;
        end
    end

    // Victim search
    always_comb
    begin
        any_inv   = |(~mask_reg);
        first_inv = '0;
        top       = 2'd0;
        first3    = '0;
        for (int w = WAYS - 1; w >= 0; w--)
            if (!mask_reg[w])
                first_inv = WAY_W'(w);
        for (int w = 0; w < WAYS; w++)
            if (row_reg.rrpv[w] > top)
                top = row_reg.rrpv[w];
        for (int w = 0; w < WAYS; w++)
            aged[w] = row_reg.rrpv[w] + (2'd3 - top);
        for (int w = WAYS - 1; w >= 0; w--)
            if (aged[w] == 2'd3)
                first3 = WAY_W'(w);
    end

    // Update path
    always_comb
    begin
        dead_old = row_reg.dead[way_reg];
        tcur     = tbl_v_reg ? tbl_q_reg : 2'd1;
        if (hit_reg)
        begin
            dead_new = 2'd0;
            t_new    = (tcur != 2'd3) ? tcur + 2'd1 : tcur;
        end
        else
        begin
            dead_new = (dead_old != 2'd3) ? dead_old + 2'd1 : dead_old;
            t_new    = (tcur != 2'd0) ? tcur - 2'd1 : tcur;
        end

        srrip    = set_reg < SET_W'(lead_reg);
        lead_sum = (LEAD_W+2)'(set_reg) + (LEAD_W+2)'(lead_reg);
        brrip    = lead_sum >= (LEAD_W+2)'(SETS);

        psel_next = psel_reg;
        if (srrip && !hit_reg && psel_reg != SEL_MAX)
            psel_next = psel_reg + SEL_BITS'(1);
        else if (brrip && hit_reg && psel_reg != '0)
            psel_next = psel_reg - SEL_BITS'(1);

        lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? 16'hB400 : 16'h0000);
        lfsr_pick = (lfsr_next[4:0] == 5'd0) ? 2'd2 : 2'd3;
        lfsr_use  = 1'b0;

        if (dead_new >= 2'd2)
            ins = 2'd3;
        else if (t_new >= 2'd2)
            ins = 2'd0;
        else if (srrip)
            ins = 2'd2;
        else if (brrip || psel_next < SEL_MID)
        begin
            ins      = lfsr_pick;
            lfsr_use = !hit_reg;
        end
        else
            ins = 2'd2;

        fin_row = row_reg;
        if (op_reg)
        begin
            fin_we              = 1'b1;
            res_way_next        = '0;
            fin_row.dead[way_reg] = dead_new;
            if (hit_reg)
            begin
                fin_row.rrpv[way_reg] = 2'd0;
                res_rrpv_next         = 2'd0;
            end
            else
            begin
                fin_row.rrpv[way_reg] = ins;
                fin_row.sig[way_reg]  = sig_reg;
                res_rrpv_next         = ins;
            end
        end
        else
        begin
            fin_we        = !any_inv;
            res_rrpv_next = 2'd0;
            res_way_next  = any_inv ? first_inv : first3;
            fin_row.rrpv  = aged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg     <= '0;
            lfsr_reg   <= 16'd1;
            psel_reg   <= SEL_MID;
            tvalid_reg <= '0;
        end
        else
        begin
            if (cmd.load && operation)
                dc_reg <= status.decay_now ? 16'd0 : dc_inc;
            if (tbl_we)
            begin
                psel_reg           <= psel_next;
                tvalid_reg[ts_reg] <= 1'b1;
                if (lfsr_use)
                    lfsr_reg <= lfsr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_way_reg  <= res_way_next;
            res_rrpv_reg <= res_rrpv_next;
        end
        if (cmd.push)
        begin
            out_way_reg  <= 4'(res_way_reg);
            out_rrpv_reg <= res_rrpv_reg;
        end
    end

    assign victim_way   = out_way_reg;
    assign written_rrpv = out_rrpv_reg;

endmodule
`default_nettype wire

// ----- rtl/drrip_ship_dead_block_replacement_unit.sv -----
`default_nettype none
// DRRIP/SHiP replacement unit with dead-block filter for a 2048-set, 16-way cache.
// One item at a time: a victim or update transfer is taken only in the idle state;
// the set's metadata row is then read into a register, the outcome table is read
// into a register, the row is written back when needed and the result registered,
// and the result is pushed to the output, after which the next transfer can be taken.
// An update that reaches the decay period first sweeps every set row, ageing its dead counters.
// A stalled result holds the next item in its push state. After reset a
// clearing pass over all 2048 rows runs before the first input transfer is taken;
// configuration writes are taken at any time.
module drrip_ship_dead_block_replacement_unit
    import drrip_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               operation,
    input  wire logic [10:0]        set_index,
    input  wire logic [3:0]         way_index,
    input  wire logic [15:0]        valid_mask,
    input  wire logic [5:0]         pc_low,
    input  wire logic [5:0]         line_addr_low,
    input  wire logic               was_hit,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              victim_way,
    output logic [1:0]              written_rrpv
);

    cmd_t    cmd;
    status_t status;

    drrip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    drrip_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .set_index     (set_index),
        .way_index     (way_index),
        .valid_mask    (valid_mask),
        .pc_low        (pc_low),
        .line_addr_low (line_addr_low),
        .was_hit       (was_hit),
        .victim_way    (victim_way),
        .written_rrpv  (written_rrpv)
    );

endmodule
`default_nettype wire

// ----- rtl/drrip_checker.sv -----
`default_nettype none
module drrip_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] victim_way,
    input wire logic [1:0] written_rrpv
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(victim_way) && $stable(written_rrpv))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while busy");

    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written_rrpv != 2'd0 |-> victim_way == 4'd0)
        else $error("update result carries a victim way");

endmodule

bind drrip_ship_dead_block_replacement_unit drrip_checker u_chk (.*);
`default_nettype wire
